FILE: rtl/eps_pkg.sv
package eps_pkg;

    localparam int START_POSITION_DEF = 32768;
    localparam int POSITION_BITS_DEF  = 16;

    localparam logic [7:0] GAIN_RESET       = 8'd1;
    localparam logic [7:0] DUTY_LIMIT_RESET = 8'd100;

    typedef enum logic [1:0] {
        FUNC_EDGE = 2'd0,
        FUNC_WRAP = 2'd1,
        FUNC_TICK = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        DIR_BRAKE   = 2'd0,
        DIR_FORWARD = 2'd1,
        DIR_REVERSE = 2'd2
    } dir_t;

    typedef enum logic [0:0] {
        REG_GAIN       = 1'b0,
        REG_DUTY_LIMIT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [1:0]  func;
        logic        phase_b_level;
        logic [15:0] capture_time;
        logic [15:0] target_position;
    } eps_item_t;

    typedef struct packed {
        logic [7:0]  drive_duty;
        logic [1:0]  bridge_direction;
        logic [15:0] position;
        logic [23:0] period_ticks;
        logic        period_fresh;
    } eps_result_t;

endpackage

FILE: rtl/eps_if.sv
interface eps_event_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic        phase_b_level;
    logic [15:0] capture_time;
    logic [15:0] target_position;

    modport source (
        output valid,
        output func,
        output phase_b_level,
        output capture_time,
        output target_position,
        input  ready
    );

    modport sink (
        input  valid,
        input  func,
        input  phase_b_level,
        input  capture_time,
        input  target_position,
        output ready
    );
endinterface

interface eps_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  drive_duty;
    logic [1:0]  bridge_direction;
    logic [15:0] position;
    logic [23:0] period_ticks;
    logic        period_fresh;

    modport source (
        output valid,
        output drive_duty,
        output bridge_direction,
        output position,
        output period_ticks,
        output period_fresh,
        input  ready
    );

    modport sink (
        input  valid,
        input  drive_duty,
        input  bridge_direction,
        input  position,
        input  period_ticks,
        input  period_fresh,
        output ready
    );
endinterface

FILE: rtl/eps_drive.sv
module eps_drive #(
    parameter int POSITION_BITS = eps_pkg::POSITION_BITS_DEF
) (
    input  logic [POSITION_BITS-1:0] position,
    input  logic [15:0]              target_position,
    input  logic [7:0]               gain,
    input  logic [7:0]               duty_limit,
    input  eps_pkg::dir_t            direction,
    output eps_pkg::dir_t            direction_next,
    output logic [7:0]               duty_next
);
    import eps_pkg::*;

    localparam int ERR_BITS = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 1;

    logic [ERR_BITS-1:0] target_ext;
    logic [ERR_BITS-1:0] position_ext;
    logic [ERR_BITS-1:0] diff;
    logic [ERR_BITS-1:0] magnitude;
    logic                negative;
    logic [7:0]          magnitude_clamp;
    logic [15:0]         product;
    logic [7:0]          duty_raw;

    always_comb
    begin
        target_ext   = ERR_BITS'(target_position);
        position_ext = ERR_BITS'(position);
        diff         = target_ext - position_ext;
        negative     = diff[ERR_BITS-1];
        magnitude    = negative ? (ERR_BITS'(0) - diff) : diff;
        // with a nonzero gain, any magnitude above 255 already drives the product past the limit
        magnitude_clamp = (magnitude > ERR_BITS'(8'hFF)) ? 8'hFF : magnitude[7:0];
        product         = 16'(magnitude_clamp) * 16'(gain);
        duty_raw        = (product > 16'(duty_limit)) ? duty_limit : product[7:0];
    end

    always_comb
    begin
        direction_next = DIR_BRAKE;
        duty_next      = 8'd0;
        if (diff != '0)
        begin
            if (!negative)
            begin
                if (direction != DIR_REVERSE)
                begin
                    direction_next = DIR_FORWARD;
                    duty_next      = duty_raw;
                end
            end
            else
            begin
                if (direction != DIR_FORWARD)
                begin
                    direction_next = DIR_REVERSE;
                    duty_next      = duty_raw;
                end
            end
        end
    end

endmodule

FILE: rtl/eps_core.sv
module eps_core #(
    parameter int START_POSITION = eps_pkg::START_POSITION_DEF,
    parameter int POSITION_BITS  = eps_pkg::POSITION_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  eps_pkg::reg_index_t cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic                step,
    input  eps_pkg::eps_item_t  item,
    output eps_pkg::eps_result_t result
);
    import eps_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
    localparam logic [POSITION_BITS-1:0] POS_RESET = POSITION_BITS'(START_POSITION);

    logic [7:0]               gain_reg;
    logic [7:0]               limit_reg;
    logic [POSITION_BITS-1:0] position_reg;
    logic [POSITION_BITS-1:0] position_next;
    dir_t                     dir_reg;
    dir_t                     dir_next;
    logic [7:0]               duty_reg;
    logic [7:0]               duty_next;
    logic                     phase_reg;
    logic                     phase_next;
    logic [15:0]              first_time_reg;
    logic [15:0]              first_time_next;
    logic [7:0]               first_wraps_reg;
    logic [7:0]               first_wraps_next;
    logic [7:0]               wrap_reg;
    logic [7:0]               wrap_next;
    logic [23:0]              period_reg;
    logic [23:0]              period_next;
    logic                     fresh_reg;
    logic                     fresh_next;
    dir_t                     tick_dir;
    logic [7:0]               tick_duty;
    logic [23:0]              later;
    logic [23:0]              earlier;

    eps_drive #(
        .POSITION_BITS (POSITION_BITS)
    ) u_drive (
        .position        (position_reg),
        .target_position (item.target_position),
        .gain            (gain_reg),
        .duty_limit      (limit_reg),
        .direction       (dir_reg),
        .direction_next  (tick_dir),
        .duty_next       (tick_duty)
    );

    assign later   = {wrap_reg, item.capture_time};
    assign earlier = {first_wraps_reg, first_time_reg};

    always_comb
    begin
        position_next    = position_reg;
        dir_next         = dir_reg;
        duty_next        = duty_reg;
        phase_next       = phase_reg;
        first_time_next  = first_time_reg;
        first_wraps_next = first_wraps_reg;
        wrap_next        = wrap_reg;
        period_next      = period_reg;
        fresh_next       = 1'b0;
        case (func_t'(item.func))
            FUNC_EDGE:
            begin
                if (!item.phase_b_level)
                begin
                    if (position_reg != POS_MAX)
                        position_next = position_reg + POSITION_BITS'(1);
                end
                else
                begin
                    if (position_reg != '0)
                        position_next = position_reg - POSITION_BITS'(1);
                end
                if (!phase_reg)
                begin
                    first_time_next  = item.capture_time;
                    first_wraps_next = wrap_reg;
                    phase_next       = 1'b1;
                end
                else
                begin
                    period_next = later - earlier;
                    phase_next  = 1'b0;
                    fresh_next  = 1'b1;
                end
            end
            FUNC_WRAP:
                wrap_next = wrap_reg + 8'd1;
            FUNC_TICK:
            begin
                dir_next  = tick_dir;
                duty_next = tick_duty;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_RESET;
            limit_reg <= DUTY_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN:       gain_reg  <= cfg_data;
                REG_DUTY_LIMIT: limit_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg    <= POS_RESET;
            dir_reg         <= DIR_BRAKE;
            duty_reg        <= 8'd0;
            phase_reg       <= 1'b0;
            first_time_reg  <= 16'd0;
            first_wraps_reg <= 8'd0;
            wrap_reg        <= 8'd0;
            period_reg      <= 24'd0;
            fresh_reg       <= 1'b0;
        end
        else if (step)
        begin
            position_reg    <= position_next;
            dir_reg         <= dir_next;
            duty_reg        <= duty_next;
            phase_reg       <= phase_next;
            first_time_reg  <= first_time_next;
            first_wraps_reg <= first_wraps_next;
            wrap_reg        <= wrap_next;
            period_reg      <= period_next;
            fresh_reg       <= fresh_next;
        end
    end

    always_comb
    begin
        result.drive_duty       = duty_reg;
        result.bridge_direction = dir_reg;
        result.position         = 16'(position_reg);
        result.period_ticks     = period_reg;
        result.period_fresh     = fresh_reg;
    end

`ifndef SYNTHESIS
    a_brake_zero_duty : assert property (@(posedge clk) disable iff (!rst_n)
        dir_reg == DIR_BRAKE |-> duty_reg == 8'd0)
        else $error("duty nonzero while braking");

    a_no_direct_reverse : assert property (@(posedge clk) disable iff (!rst_n)
        dir_reg == DIR_FORWARD |=> dir_reg != DIR_REVERSE)
        else $error("drive reversed without a brake tick");

    a_wrap_advance : assert property (@(posedge clk) disable iff (!rst_n)
        step && item.func == FUNC_WRAP |=> wrap_reg == 8'($past(wrap_reg) + 8'd1))
        else $error("wrap counter did not advance");

    a_fresh_from_edge : assert property (@(posedge clk) disable iff (!rst_n)
        step && item.func != FUNC_EDGE |=> !fresh_reg)
        else $error("period marked fresh without an encoder edge");
`endif

endmodule

FILE: rtl/encoder_position_servo_top.sv
// Results are registered: an item passes the input register and then the result register,
// and results.valid rises once the item has moved into the result register.
// Throughput: one item per cycle while results.ready is high; a held result stalls both stages.
// Reset (rst_n low, asynchronous): position to START_POSITION, brake with duty 0,
// period, wrap and edge state to 0, gain to 1, duty limit to 100, both stages empty.
module encoder_position_servo_top #(
    parameter int START_POSITION = eps_pkg::START_POSITION_DEF,
    parameter int POSITION_BITS  = eps_pkg::POSITION_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    eps_event_if.sink         events,
    eps_result_if.source      results,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [7:0]        cfg_data
);
    import eps_pkg::*;

    logic        in_valid_reg;
    eps_item_t   item_reg;
    logic        out_valid_reg;
    logic        step;
    eps_result_t result;

    // advance the input stage whenever the result register is free or being drained
    assign step         = in_valid_reg && (!out_valid_reg || results.ready);
    assign events.ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (events.ready)
                in_valid_reg <= events.valid;
            if (step)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (events.valid && events.ready)
        begin
            item_reg.func            <= events.func;
            item_reg.phase_b_level   <= events.phase_b_level;
            item_reg.capture_time    <= events.capture_time;
            item_reg.target_position <= events.target_position;
        end
    end

    eps_core #(
        .START_POSITION (START_POSITION),
        .POSITION_BITS  (POSITION_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (reg_index_t'(cfg_index)),
        .cfg_data  (cfg_data),
        .step      (step),
        .item      (item_reg),
        .result    (result)
    );

    assign results.valid            = out_valid_reg;
    assign results.drive_duty       = result.drive_duty;
    assign results.bridge_direction = result.bridge_direction;
    assign results.position         = result.position;
    assign results.period_ticks     = result.period_ticks;
    assign results.period_fresh     = result.period_fresh;

endmodule

FILE: dv/encoder_position_servo_top_test.sv
module encoder_position_servo_top_test;
    import eps_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int REPORT_LIMIT = 10;
    localparam int SETTLE_CYCLES = 4;

    logic clk;
    logic rst_n;
    logic cfg_we;
    reg_index_t cfg_index;
    logic [7:0] cfg_data;

    eps_event_if events();
    eps_result_if results();

    encoder_position_servo_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .events    (events),
        .results   (results),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // servo state mirror
    logic [15:0] pos_q;
    dir_t        dir_q;
    logic [7:0]  duty_q;
    logic        phase_q;
    logic [15:0] first_time_q;
    logic [7:0]  first_wraps_q;
    logic [7:0]  wraps_q;
    logic [23:0] period_q;
    logic [7:0]  gain_q;
    logic [7:0]  limit_q;

    eps_result_t servo_results[$];
    eps_result_t got_result;
    eps_result_t want_result;
    int error_count;
    int cycle_count;
    bit steady;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic eps_result_t servo_step(input logic [1:0] fn, input logic b_level,
                                               input logic [15:0] cap, input logic [15:0] tgt);
        eps_result_t r;
        int err;
        int unsigned mag;
        int unsigned prod;
        r.period_fresh = 1'b0;
        case (fn)
            FUNC_EDGE:
            begin
                if (!b_level)
                begin
                    if (pos_q != 16'hFFFF)
                        pos_q = pos_q + 16'd1;
                end
                else if (pos_q != 16'h0000)
                begin
                    pos_q = pos_q - 16'd1;
                end
                if (!phase_q)
                begin
                    first_time_q = cap;
                    first_wraps_q = wraps_q;
                    phase_q = 1'b1;
                end
                else
                begin
                    period_q = {wraps_q, cap} - {first_wraps_q, first_time_q};
                    phase_q = 1'b0;
                    r.period_fresh = 1'b1;
                end
            end
            FUNC_WRAP:
                wraps_q = wraps_q + 8'd1;
            FUNC_TICK:
            begin
                err = int'(tgt) - int'(pos_q);
                mag = (err < 0) ? -err : err;
                if (err == 0 || (err > 0 && dir_q == DIR_REVERSE)
                        || (err < 0 && dir_q == DIR_FORWARD))
                begin
                    dir_q = DIR_BRAKE;
                    duty_q = 8'd0;
                end
                else
                begin
                    dir_q = (err > 0) ? DIR_FORWARD : DIR_REVERSE;
                    prod = mag * gain_q;
                    duty_q = (prod > limit_q) ? limit_q : prod[7:0];
                end
            end
            default: ;
        endcase
        r.drive_duty = duty_q;
        r.bridge_direction = dir_q;
        r.position = pos_q;
        r.period_ticks = period_q;
        return r;
    endfunction

    // hold valid after the transfer; the next call or settle decides what follows
    task automatic send_event(input logic [1:0] fn, input logic b_level,
                              input logic [15:0] cap, input logic [15:0] tgt);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 25)
        begin
            events.valid = 1'b0;
            @(negedge clk);
        end
        events.valid = 1'b1;
        events.func = fn;
        events.phase_b_level = b_level;
        events.capture_time = cap;
        events.target_position = tgt;
        do
            @(posedge clk);
        while (!events.ready);
        servo_results.push_back(servo_step(fn, b_level, cap, tgt));
    endtask

    task automatic settle();
        @(negedge clk);
        events.valid = 1'b0;
        while (servo_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [7:0] value);
        settle();
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(posedge clk);
        if (idx == REG_GAIN)
            gain_q = value;
        else
            limit_q = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial
    begin
        results.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            results.ready = steady || ($urandom_range(99) >= 25);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && results.valid && results.ready)
        begin
            got_result.drive_duty = results.drive_duty;
            got_result.bridge_direction = results.bridge_direction;
            got_result.position = results.position;
            got_result.period_ticks = results.period_ticks;
            got_result.period_fresh = results.period_fresh;
            if (servo_results.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected result: duty %0d dir %0d pos %0d period %0d fresh %0d",
                             got_result.drive_duty, got_result.bridge_direction,
                             got_result.position, got_result.period_ticks,
                             got_result.period_fresh);
            end
            else
            begin
                want_result = servo_results.pop_front();
                if (got_result.drive_duty !== want_result.drive_duty
                        || got_result.bridge_direction !== want_result.bridge_direction
                        || got_result.position !== want_result.position
                        || got_result.period_ticks !== want_result.period_ticks
                        || got_result.period_fresh !== want_result.period_fresh)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                    begin
                        $display("mismatch at cycle %0d", cycle_count);
                        $display("  expected duty %0d dir %0d pos %0d period %0d fresh %0d",
                                 want_result.drive_duty, want_result.bridge_direction,
                                 want_result.position, want_result.period_ticks,
                                 want_result.period_fresh);
                        $display("  actual   duty %0d dir %0d pos %0d period %0d fresh %0d",
                                 got_result.drive_duty, got_result.bridge_direction,
                                 got_result.position, got_result.period_ticks,
                                 got_result.period_fresh);
                    end
                end
            end
        end
    end

    task automatic test_reset_values();
        send_event(FUNC_UNUSED, 1'b1, 16'hFFFF, 16'hFFFF);
        send_event(FUNC_WRAP, 1'b0, 16'h0000, 16'h0000);
    endtask

    task automatic test_encoder_edges();
        send_event(FUNC_EDGE, 1'b0, 16'h0000, 16'h0000);
        send_event(FUNC_EDGE, 1'b1, 16'hFFFF, 16'h0000);
        send_event(FUNC_WRAP, 1'b0, 16'h1234, 16'h0000);
        send_event(FUNC_EDGE, 1'b0, 16'hFFFF, 16'h0000);
        send_event(FUNC_WRAP, 1'b1, 16'h0000, 16'hFFFF);
        send_event(FUNC_EDGE, 1'b1, 16'h0000, 16'h0000);
    endtask

    task automatic test_control_ticks();
        send_event(FUNC_TICK, 1'b0, 16'h0000, pos_q);
        send_event(FUNC_TICK, 1'b0, 16'h0000, 16'hFFFF);
        send_event(FUNC_TICK, 1'b0, 16'h0000, pos_q - 16'd8);
        send_event(FUNC_TICK, 1'b0, 16'h0000, pos_q - 16'd8);
        send_event(FUNC_TICK, 1'b0, 16'h0000, pos_q + 16'd2);
        send_event(FUNC_TICK, 1'b0, 16'h0000, pos_q + 16'd2);
    endtask

    task automatic test_register_extremes();
        write_reg(REG_GAIN, 8'd255);
        write_reg(REG_DUTY_LIMIT, 8'd255);
        send_event(FUNC_TICK, 1'b0, 16'h0000, pos_q + 16'd1);
        send_event(FUNC_TICK, 1'b0, 16'h0000, pos_q + 16'd2);
        write_reg(REG_GAIN, 8'd0);
        send_event(FUNC_TICK, 1'b0, 16'h0000, 16'hFFFF);
        write_reg(REG_GAIN, 8'd255);
        write_reg(REG_DUTY_LIMIT, 8'd0);
        send_event(FUNC_TICK, 1'b0, 16'h0000, 16'h0000);
        send_event(FUNC_TICK, 1'b0, 16'h0000, 16'h0000);
    endtask

    task automatic test_random_traffic(input int count, input logic [7:0] gain,
                                       input logic [7:0] limit, input bit no_idle);
        int pick;
        logic [15:0] tgt;
        write_reg(REG_GAIN, gain);
        write_reg(REG_DUTY_LIMIT, limit);
        steady = no_idle;
        repeat (count)
        begin
            pick = $urandom_range(99);
            tgt = 16'($urandom);
            if (pick < 45)
            begin
                send_event(FUNC_EDGE, 1'($urandom_range(1)), 16'($urandom), tgt);
            end
            else if (pick < 65)
            begin
                send_event(FUNC_WRAP, 1'($urandom_range(1)), 16'($urandom), tgt);
            end
            else if (pick < 95)
            begin
                case ($urandom_range(3))
                    0: tgt = pos_q;
                    1, 2: tgt = pos_q + 16'($urandom_range(400)) - 16'd200;
                    default: ;
                endcase
                send_event(FUNC_TICK, 1'($urandom_range(1)), 16'($urandom), tgt);
            end
            else
            begin
                send_event(FUNC_UNUSED, 1'($urandom_range(1)), 16'($urandom), tgt);
            end
        end
        steady = 1'b0;
    endtask

    // drive long one-way edge runs and full-scale position errors
    task automatic test_long_runs();
        write_reg(REG_GAIN, 8'd1);
        write_reg(REG_DUTY_LIMIT, 8'd100);
        steady = 1'b1;
        repeat (100) send_event(FUNC_EDGE, 1'b1, 16'($urandom), 16'h0000);
        send_event(FUNC_TICK, 1'b0, 16'h0000, 16'h0000);
        send_event(FUNC_TICK, 1'b0, 16'h0000, 16'hFFFF);
        repeat (100) send_event(FUNC_EDGE, 1'b0, 16'($urandom), 16'h0000);
        send_event(FUNC_TICK, 1'b0, 16'h0000, 16'hFFFF);
        send_event(FUNC_TICK, 1'b0, 16'h0000, 16'h0000);
        send_event(FUNC_TICK, 1'b0, 16'h0000, 16'h0000);
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_GAIN;
        cfg_data = 8'd0;
        events.valid = 1'b0;
        events.func = FUNC_EDGE;
        events.phase_b_level = 1'b0;
        events.capture_time = 16'h0000;
        events.target_position = 16'h0000;
        steady = 1'b0;
        error_count = 0;
        cycle_count = 0;
        pos_q = 16'(START_POSITION_DEF);
        dir_q = DIR_BRAKE;
        duty_q = 8'd0;
        phase_q = 1'b0;
        first_time_q = 16'h0000;
        first_wraps_q = 8'd0;
        wraps_q = 8'd0;
        period_q = 24'd0;
        gain_q = GAIN_RESET;
        limit_q = DUTY_LIMIT_RESET;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_encoder_edges();
        test_control_ticks();
        test_register_extremes();
        test_random_traffic(240, GAIN_RESET, DUTY_LIMIT_RESET, 1'b0);
        test_random_traffic(240, 8'd0, 8'd255, 1'b0);
        test_random_traffic(240, 8'd255, 8'd255, 1'b1);
        test_random_traffic(240, 8'd255, 8'd0, 1'b0);
        test_random_traffic(240, 8'($urandom), 8'($urandom), 1'b0);
        test_random_traffic(240, 8'($urandom_range(8)), 8'($urandom), 1'b0);
        test_long_runs();
        settle();

        if (error_count == 0 && servo_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
